/* src/nnt_pkg.sv */
package nnt_pkg;

  localparam int MAX_CITIES  = 64;
  localparam int DIST_BITS   = 32;
  localparam int CITY_W      = $clog2(MAX_CITIES);
  localparam int CNT_W       = $clog2(MAX_CITIES + 1);
  localparam int STORE_DEPTH = (MAX_CITIES * (MAX_CITIES - 1)) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 38;
  localparam int ACC_W       = 39;

  localparam logic ActionLoad  = 1'b0;
  localparam logic ActionStart = 1'b1;

  typedef struct packed {
    logic        action;
    logic [5:0]  row_city;
    logic [5:0]  col_city;
    logic [31:0] dist_value;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  city;
    logic [37:0] tour_length;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Triangular index of an unordered pair of different cities.
  function automatic logic [ADDR_W-1:0] pair_addr(input logic [CITY_W-1:0] a,
                                                  input logic [CITY_W-1:0] b);
    logic [CITY_W-1:0]   hi;
    logic [CITY_W-1:0]   lo;
    logic [2*CITY_W-1:0] prod;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = (2*CITY_W)'(hi) * (2*CITY_W)'(hi - 1'b1);
    return ADDR_W'(prod >> 1) + ADDR_W'(lo);
  endfunction

endpackage

/* src/nnt_dist_mem.sv */
module nnt_dist_mem
  import nnt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_W-1:0]    waddr_i,
  input  logic [DIST_BITS-1:0] wdata_i,
  input  rd_req_t              rd_req_i,
  output logic [DIST_BITS-1:0] rdata_o
);

  logic [DIST_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rdata_o <= mem[rd_req_i.addr];
    end
  end

endmodule

/* src/nnt_seq.sv */
module nnt_seq
  import nnt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CNT_W-1:0]     n_i,
  input  logic [DIST_BITS-1:0] rd_data_i,
  input  logic                 out_free_i,
  output rd_req_t              rd_req_o,
  output logic                 emit_o,
  output out_beat_t            beat_o,
  output logic                 busy_o
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EMIT      = 7'b0000010,
    S_SCAN      = 7'b0000100,
    S_DRAIN     = 7'b0001000,
    S_STEP      = 7'b0010000,
    S_CLOSE     = 7'b0100000,
    S_CLOSE_ADD = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CITY_W-1:0]     j_q, j_d;
  logic                  pv_q, pv_d;
  logic [CITY_W-1:0]     pj_q, pj_d;
  logic                  found_q, found_d;
  logic [DIST_BITS-1:0]  best_q, best_d;
  logic [CITY_W-1:0]     next_q, next_d;
  logic [MAX_CITIES-1:0] visited_q, visited_d;
  logic [CITY_W-1:0]     cur_q, cur_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  logic                  done_q, done_d;
  out_beat_t             beat_q, beat_d;

  // The one adder: it takes the chosen edge or the closing edge.
  logic [DIST_BITS-1:0]  addend;
  logic [ACC_W-1:0]      acc_sum;

  assign addend  = state_q == S_CLOSE_ADD ? rd_data_i : best_q;
  assign acc_sum = acc_q + ACC_W'(addend);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    j_d       = j_q;
    pv_d      = 1'b0;
    pj_d      = pj_q;
    found_d   = found_q;
    best_d    = best_q;
    next_d    = next_q;
    visited_d = visited_q;
    cur_d     = cur_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    done_d    = done_q;
    beat_d    = beat_q;
    rd_req_o  = '{en: 1'b0, addr: pair_addr(cur_q, j_q)};
    emit_o    = 1'b0;

    // Compare stage, in the cycle after the read; strict compare keeps the lowest index on a tie.
    if (pv_q && (!found_q || rd_data_i < best_q)) begin
      found_d = 1'b1;
      best_d  = rd_data_i;
      next_d  = pj_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i && n_i != '0) begin
          n_d       = n_i;
          visited_d = MAX_CITIES'(1);
          cur_d     = '0;
          acc_d     = '0;
          pos_d     = CNT_W'(1);
          done_d    = n_i == CNT_W'(1);
          beat_d    = '{city: '0, tour_length: '0, last: n_i == CNT_W'(1)};
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          j_d     = '0;
          found_d = 1'b0;
          state_d = done_q ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        rd_req_o.en = 1'b1;
        pv_d        = !visited_q[j_q];
        pj_d        = j_q;
        j_d         = j_q + 1'b1;
        if ({1'b0, j_q} == n_q - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        visited_d[next_q] = 1'b1;
        acc_d   = acc_sum;
        cur_d   = next_q;
        pos_d   = pos_q + 1'b1;
        beat_d  = '{city: next_q, tour_length: '0, last: 1'b0};
        done_d  = 1'b0;
        state_d = (pos_q + 1'b1 == n_q) ? S_CLOSE : S_EMIT;
      end
      S_CLOSE: begin
        rd_req_o = '{en: 1'b1, addr: pair_addr(cur_q, '0)};
        state_d  = S_CLOSE_ADD;
      end
      S_CLOSE_ADD: begin
        acc_d              = acc_sum;
        beat_d.tour_length = acc_sum[LEN_W-1:0];
        beat_d.last        = 1'b1;
        done_d             = 1'b1;
        state_d            = S_EMIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      j_q       <= '0;
      pv_q      <= 1'b0;
      found_q   <= 1'b0;
      visited_q <= '0;
      cur_q     <= '0;
      acc_q     <= '0;
      pos_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      j_q       <= j_d;
      pv_q      <= pv_d;
      found_q   <= found_d;
      visited_q <= visited_d;
      cur_q     <= cur_d;
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pj_q   <= pj_d;
    best_q <= best_d;
    next_q <= next_d;
    beat_q <= beat_d;
  end

  assign beat_o = beat_q;
  assign busy_o = state_q != S_IDLE;

endmodule

/* src/nearest_neighbor_tour.sv */
// Greedy nearest-neighbor tour builder over a symmetric distance half-matrix.
//
// The input channel carries one beat per item. A load beat (action 0) writes
// the distance between two different cities into the distance memory; a load
// naming the same city twice is dropped. A start beat (action 1) builds a tour
// over cities 0 to city_count-1, starting at city 0 and always moving to the
// nearest unvisited city, the lowest index winning a tie. The output channel
// gives one beat per city in visiting order; the final beat has last set and
// carries the closed tour length, including the edge back to city 0.
// A start for N cities (N of two or more) reads one distance per cycle while it
// scans: each position after city 0 reads all N cities, then drains, steps and
// emits; the closing edge back to city 0 takes one more read and add. The input
// stalls until the last beat has entered the output register. City 0 goes
// through the sequencer's beat register, then the output register. The city_count
// register is written through cfg_we_i and cfg_wdata_i, by the user only while
// the block is idle (the block does not enforce this); values above 64 act as 64
// and zero makes a start give nothing. Reset sets city_count to 64 and empties
// the output register; the distance memory is not cleared and must be loaded
// before use. When the receiver stalls, the pending beat holds steady and the sequencer waits until it is taken.
module nearest_neighbor_tour
  import nnt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_beat_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_beat_t  out_beat_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  logic [CNT_W-1:0]     city_count_q;
  logic [CNT_W-1:0]     n_eff;
  logic                 busy;
  logic                 in_accept;
  logic                 start;
  logic                 load_we;
  rd_req_t              rd_req;
  logic [DIST_BITS-1:0] rd_data;
  logic                 out_free;
  logic                 emit;
  out_beat_t            beat;
  logic                 out_valid_q;
  out_beat_t            out_beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CNT_W'(MAX_CITIES);
    end else if (cfg_we_i) begin
      city_count_q <= CNT_W'(cfg_wdata_i);
    end
  end

  assign n_eff = (city_count_q > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES) : city_count_q;

  // Input is taken only while the sequencer is idle.
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;
  assign start      = in_accept && in_beat_i.action == ActionStart;
  assign load_we    = in_accept && in_beat_i.action == ActionLoad &&
                      in_beat_i.row_city != in_beat_i.col_city;

  nnt_dist_mem u_mem (
    .clk_i    (clk_i),
    .we_i     (load_we),
    .waddr_i  (pair_addr(in_beat_i.row_city, in_beat_i.col_city)),
    .wdata_i  (in_beat_i.dist_value[DIST_BITS-1:0]),
    .rd_req_i (rd_req),
    .rdata_o  (rd_data)
  );

  nnt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .n_i        (n_eff),
    .rd_data_i  (rd_data),
    .out_free_i (out_free),
    .rd_req_o   (rd_req),
    .emit_o     (emit),
    .beat_o     (beat),
    .busy_o     (busy)
  );

  // Output register: a new beat may enter in the cycle the old one leaves.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_beat_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import nnt_pkg::*;

  // The run stops here, well past the slowest correct run.
  localparam int CYCLE_LIMIT   = 1_500_000;
  // Idle cycles before a city_count write once no tour beat is pending.
  localparam int SETTLE_CYCLES = 16;
  // Cycles left to run after the last expected beat has arrived.
  localparam int TAIL_CYCLES   = 32;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES   = 600;
  // Useful input beats in the random part.
  localparam int RANDOM_ITEMS  = 140;

  typedef enum logic {RowCfg, RowBeat} row_kind_e;

  // One row of the directed table. A row either writes city_count or sends one
  // input beat. A start row with typed set carries its expected tour (at most
  // two beats) instead of asking the tour predictor.
  typedef struct packed {
    row_kind_e  kind;
    logic [6:0] cfg_val;
    in_beat_t   beat;
    logic       typed;
    logic [1:0] n_typed;
    out_beat_t  first_due;
    out_beat_t  second_due;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid_q;
  logic       in_stall;
  in_beat_t   in_beat_q;
  logic       out_valid;
  logic       out_stall_q;
  out_beat_t  out_beat;
  logic       cfg_we_q;
  logic [6:0] cfg_wdata_q;

  // Shadow of the block's state used to forecast each tour.
  logic [DIST_BITS-1:0] dist_mirror [0:STORE_DEPTH-1];
  logic [6:0]           count_mirror;

  // Tour beats that are owed by the block, oldest first.
  out_beat_t tour_due [$];
  out_beat_t due_beat;
  plan_row_t plan [$];

  int  errors;
  int  cycle_count;
  int  burst_left;
  bit  squeeze_req;

  nearest_neighbor_tour DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat_q),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall_q),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we_q),
    .cfg_wdata_i (cfg_wdata_q)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a tour that never finishes ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tour predictor.
  // ---------------------------------------------------------------------------

  // Slot of an unordered pair of different cities in the half-matrix.
  function automatic int tri_slot(input logic [5:0] a, input logic [5:0] b);
    int hi;
    int lo;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    return hi * (hi - 1) / 2 + lo;
  endfunction

  // A city is always at distance zero from itself.
  function automatic logic [DIST_BITS-1:0] gap_between(input logic [5:0] a,
                                                       input logic [5:0] b);
    if (a == b) return '0;
    return dist_mirror[tri_slot(a, b)];
  endfunction

  // Applies one accepted input beat to the shadow state. A load updates the
  // distance shadow; a start builds the greedy tour and queues its beats.
  task automatic forecast(input in_beat_t b);
    logic [63:0]          seen;
    logic [5:0]           here;
    logic [5:0]           pick;
    logic [DIST_BITS-1:0] best;
    logic [DIST_BITS-1:0] d;
    logic [ACC_W-1:0]     acc;
    out_beat_t            tour [0:63];
    bit                   found;
    int                   n;
    int                   pos;
    int                   j;
    if (b.action == ActionLoad) begin
      // A load that names the same city twice leaves the store alone.
      if (b.row_city != b.col_city)
        dist_mirror[tri_slot(b.row_city, b.col_city)] = b.dist_value;
    end else begin
      // Counts above the store size act as the full store; zero gives nothing.
      n = (count_mirror > MAX_CITIES) ? MAX_CITIES : int'(count_mirror);
      if (n != 0) begin
        seen    = '0;
        seen[0] = 1'b1;
        here    = '0;
        acc     = '0;
        tour[0] = '0;
        for (pos = 1; pos < n; pos++) begin
          found = 1'b0;
          best  = '0;
          pick  = '0;
          for (j = 0; j < n; j++) begin
            if (!seen[j]) begin
              d = gap_between(here, 6'(j));
              // Strict compare: the lowest index keeps a tie.
              if (!found || d < best) begin
                found = 1'b1;
                best  = d;
                pick  = 6'(j);
              end
            end
          end
          seen[pick] = 1'b1;
          acc        = acc + ACC_W'(best);
          here       = pick;
          tour[pos]  = {pick, 38'd0, 1'b0};
        end
        // Close the loop back to city 0; a single city adds nothing.
        acc = acc + ACC_W'(gap_between(here, 6'd0));
        tour[n-1].tour_length = acc[LEN_W-1:0];
        tour[n-1].last        = 1'b1;
        for (j = 0; j < n; j++) tour_due.push_back(tour[j]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Gap before the next beat: mostly none, some short, a few long, and now
  // and then a long run of back-to-back beats.
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one beat and holds it until the block takes it. Loads always go
  // to the predictor so the distance shadow stays current; a start goes
  // there only when its tour is not typed into the table.
  task automatic send_beat(input in_beat_t b, input bit use_model);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid_q <= 1'b1;
    in_beat_q  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.action == ActionLoad || use_model) forecast(b);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid_q <= 1'b0;
  endtask

  // city_count is only written while the block is idle: every owed beat has
  // come back, and a start with nothing to emit has had time to finish.
  task automatic apply_cfg(input logic [6:0] v);
    idle_input();
    while (tour_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we_q     <= 1'b1;
    cfg_wdata_q  <= v;
    count_mirror = v;
    @(negedge clk);
    cfg_we_q <= 1'b0;
  endtask

  // Distances lean toward tiny values so that ties are common, with the
  // extremes and full-range values mixed in.
  function automatic logic [31:0] rand_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'($urandom_range(0, 3));
    if (r < 35) return 32'd0;
    if (r < 45) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // A random load. Most name two different cities inside the tour in use,
  // some reach anywhere in the store, and a few name one city twice.
  function automatic in_beat_t rand_load(input int span);
    int       r;
    int       a;
    int       b;
    in_beat_t beat;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      a = $urandom_range(0, MAX_CITIES - 1);
      b = a;
    end else if (r < 3) begin
      a = $urandom_range(0, MAX_CITIES - 1);
      b = $urandom_range(0, MAX_CITIES - 1);
      while (b == a) b = $urandom_range(0, MAX_CITIES - 1);
    end else begin
      a = $urandom_range(0, span - 1);
      b = $urandom_range(0, span - 1);
      while (b == a) b = $urandom_range(0, span - 1);
    end
    beat = {ActionLoad, 6'(a), 6'(b), rand_distance()};
    return beat;
  endfunction

  // Start beats carry random junk in the fields that a start ignores.
  function automatic in_beat_t rand_start();
    in_beat_t beat;
    beat = {ActionStart, 6'($urandom), 6'($urandom), 32'($urandom)};
    return beat;
  endfunction

  task automatic add_cfg(input logic [6:0] v);
    plan_row_t row;
    row         = '0;
    row.kind    = RowCfg;
    row.cfg_val = v;
    plan.push_back(row);
  endtask

  task automatic add_beat(input in_beat_t b);
    plan_row_t row;
    row      = '0;
    row.kind = RowBeat;
    row.beat = b;
    plan.push_back(row);
  endtask

  task automatic add_typed_start(input in_beat_t b, input logic [1:0] n,
                                 input out_beat_t first, input out_beat_t second);
    plan_row_t row;
    row            = '0;
    row.kind       = RowBeat;
    row.beat       = b;
    row.typed      = 1'b1;
    row.n_typed    = n;
    row.first_due  = first;
    row.second_due = second;
    plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. It stalls in short and long spells, has stall-free
  // stretches, and once holds off for a long time when asked, so that the
  // tour sequencer backs up and the block stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    wait (rst_n === 1'b1);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        @(negedge clk);
        out_stall_q <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 15) begin
          @(negedge clk);
          out_stall_q <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (mode < 65) begin
          @(negedge clk);
          out_stall_q <= 1'b0;
          @(posedge clk);
        end else if (mode < 93) begin
          @(negedge clk);
          out_stall_q <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          @(negedge clk);
          out_stall_q <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Every accepted output beat is matched against the oldest
  // owed beat, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall_q) begin
      if (tour_due.size() == 0) begin
        $display("%0t: result beat with nothing owed, expected none, actual city %0d",
                 $time, out_beat.city);
        errors++;
      end else begin
        due_beat = tour_due.pop_front();
        if (out_beat.city != due_beat.city) begin
          $display("%0t: city expected %0d actual %0d", $time, due_beat.city,
                   out_beat.city);
          errors++;
        end
        if (out_beat.tour_length != due_beat.tour_length) begin
          $display("%0t: tour_length expected %0d actual %0d", $time,
                   due_beat.tour_length, out_beat.tour_length);
          errors++;
        end
        if (out_beat.last != due_beat.last) begin
          $display("%0t: last expected %0b actual %0b", $time, due_beat.last,
                   out_beat.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int        hi;
    int        lo;
    int        k;
    int        pick;
    int        n;
    int        span;
    int        items_done;
    int        big_left;
    bit        squeezed;
    in_beat_t  b;
    logic [31:0] d;

    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid_q   = 1'b0;
    in_beat_q    = '0;
    out_stall_q  = 1'b0;
    cfg_we_q     = 1'b0;
    cfg_wdata_q  = '0;
    errors       = 0;
    cycle_count  = 0;
    burst_left   = 0;
    squeeze_req  = 1'b0;
    count_mirror = 7'd64;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The distance memory is not cleared by reset, and a tour reads every
    // pair among its cities. Loading the whole half-matrix first means no
    // later tour can touch an entry that was never written. Pairs go in
    // either order to exercise the row/column swap.
    for (hi = 1; hi < MAX_CITIES; hi++) begin
      for (lo = 0; lo < hi; lo++) begin
        d = rand_distance();
        if ($urandom_range(0, 1) == 1)
          b = {ActionLoad, 6'(lo), 6'(hi), d};
        else
          b = {ActionLoad, 6'(hi), 6'(lo), d};
        send_beat(b, 1'b1);
      end
    end

    // Directed table.
    // Full tour at the reset value of city_count, with junk in unused fields.
    add_beat({ActionStart, 6'd63, 6'd63, 32'hFFFF_FFFF});
    // A single city: the tour is city 0 alone with length zero.
    add_cfg(7'd1);
    add_typed_start({ActionStart, 6'd0, 6'd0, 32'd0}, 2'd1,
                    {6'd0, 38'd0, 1'b1}, '0);
    // Zero cities: a start gives no beats at all.
    add_cfg(7'd0);
    add_typed_start({ActionStart, 6'd21, 6'd42, 32'hA5A5_5A5A}, 2'd0, '0, '0);
    // Two cities at the largest distance: the closed tour is twice it.
    add_cfg(7'd2);
    add_beat({ActionLoad, 6'd0, 6'd1, 32'hFFFF_FFFF});
    add_typed_start({ActionStart, 6'd0, 6'd0, 32'd0}, 2'd2,
                    {6'd0, 38'd0, 1'b0}, {6'd1, 38'h1_FFFF_FFFE, 1'b1});
    // Same pair loaded in reverse order with zero.
    add_beat({ActionLoad, 6'd1, 6'd0, 32'd0});
    add_typed_start({ActionStart, 6'd63, 6'd0, 32'd0}, 2'd2,
                    {6'd0, 38'd0, 1'b0}, {6'd1, 38'd0, 1'b1});
    // A load naming one city twice must not disturb anything.
    add_beat({ActionLoad, 6'd1, 6'd1, 32'hFFFF_FFFF});
    add_beat({ActionStart, 6'd0, 6'd0, 32'd0});
    // Three cities with a tie from city 0: the lower index wins.
    add_cfg(7'd3);
    add_beat({ActionLoad, 6'd0, 6'd1, 32'd7});
    add_beat({ActionLoad, 6'd2, 6'd0, 32'd7});
    add_beat({ActionLoad, 6'd1, 6'd2, 32'hFFFF_FFFF});
    add_beat({ActionStart, 6'd0, 6'd0, 32'd0});
    // Top city indexes, then a count beyond the store that acts as the full one.
    add_beat({ActionLoad, 6'd63, 6'd62, 32'd0});
    add_beat({ActionLoad, 6'd0, 6'd63, 32'hFFFF_FFFF});
    add_cfg(7'd127);
    add_beat({ActionStart, 6'd0, 6'd63, 32'h0000_0001});
    add_cfg(7'd64);
    add_beat({ActionStart, 6'd63, 6'd0, 32'h8000_0000});

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        apply_cfg(plan[i].cfg_val);
      end else if (plan[i].typed) begin
        send_beat(plan[i].beat, 1'b0);
        if (plan[i].n_typed >= 2'd1) tour_due.push_back(plan[i].first_due);
        if (plan[i].n_typed >= 2'd2) tour_due.push_back(plan[i].second_due);
      end else begin
        send_beat(plan[i].beat, 1'b1);
      end
    end

    // Random part, in phases. Each phase picks a city count (mostly small,
    // sometimes zero or one, a few at or beyond the full store) and then sends
    // a short burst of loads and starts under it.
    items_done = 0;
    big_left   = 3;
    squeezed   = 1'b0;
    while (items_done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        n = 0;
      end else if (pick == 1) begin
        n = 1;
      end else if (pick == 2 && big_left > 0) begin
        big_left--;
        n = ($urandom_range(0, 1) == 1) ? MAX_CITIES : $urandom_range(65, 127);
      end else begin
        n = $urandom_range(2, 16);
      end
      apply_cfg(7'(n));
      span = (n > MAX_CITIES) ? MAX_CITIES : n;
      if (span < 2) span = 2;
      k = $urandom_range(3, 10);
      repeat (k) begin
        if ($urandom_range(0, 9) < 3) begin
          // The first decent-sized tour runs into the long receiver hold-off
          // while loads keep queuing behind it.
          if (!squeezed && n >= 4) begin
            squeeze_req = 1'b1;
            squeezed    = 1'b1;
          end
          send_beat(rand_start(), 1'b1);
          if (n != 0) items_done++;
        end else begin
          b = rand_load(span);
          send_beat(b, 1'b1);
          if (b.row_city != b.col_city) items_done++;
        end
      end
    end

    // Drain: wait for every owed beat, then let the block run on a little.
    idle_input();
    while (tour_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && tour_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/nnt_pkg.sv
src/nnt_dist_mem.sv
src/nnt_seq.sv
src/nearest_neighbor_tour.sv
bench/tb_top.sv
